// ===== sv/park_miller_buffered_stream_macros.svh =====
// ---------------------------------------------------------------------------
// Park-Miller buffered stream: assertion macros
// Shared concurrent-assertion forms, clocked on the rising edge and muted
// while reset is high.
// ---------------------------------------------------------------------------
`ifndef PARK_MILLER_BUFFERED_STREAM_MACROS_SVH
`define PARK_MILLER_BUFFERED_STREAM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pmbs_pkg.sv =====
// ---------------------------------------------------------------------------
// Park-Miller buffered stream: package
// Opcodes, generator constants, controller states and the command/status
// bundles between controller and datapath.
// ---------------------------------------------------------------------------
package pmbs_pkg;

  // Opcodes carried in the input tuser field
  localparam logic [2:0] OP_DRAW   = 3'd0;
  localparam logic [2:0] OP_REFILL = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_RESEED = 3'd4;

  // Minimal-standard generator constants
  localparam logic [14:0] PM_MULT     = 15'd16807;
  localparam logic [31:0] PM_MODULUS  = 32'h7FFF_FFFF;
  localparam logic [31:0] SEED_MAX    = 32'h8000_0000;
  localparam logic [30:0] FALLBACK_RST = 31'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DRAW_MUL,
    ST_DRAW_RED,
    ST_SEL_MUL,
    ST_SEL_RED,
    ST_PICK,
    ST_FILL_MUL,
    ST_FILL_RED,
    ST_RD_PICK,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_STEP,
    RES_MEM
  } res_src_t;

  typedef struct packed {
    logic     latch_item;
    logic     load_seed_frac;
    logic     load_seed_fallback;
    logic     mul;
    logic     reduce;
    logic     pick_load;
    logic     clr_cnt;
    logic     fill_write;
    logic     rd_idx;
    logic     rd_pick;
    logic     res_load;
    res_src_t res_src;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       frac_ok;
    logic       fill_last;
    logic       filled;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== sv/park_miller_buffered_stream.sv =====
// ---------------------------------------------------------------------------
// Park-Miller buffered stream: top level
// Minimal-standard generator (x16807 mod 2^31-1) with an entry buffer that a
// refill loads and that can be read back by entry.
// ---------------------------------------------------------------------------
//
//   channel   direction  signals                        beat
//   s_*       in         tvalid tready tdata tuser      one command
//   m_*       out        tvalid tready tdata            one 31-bit value
//   cfg_*     in         valid ready data               fallback seed write
//
// A refill, a set seed with an in-range fraction and a reseed each run 129
// dependent steps at the default depth, each a multiply and a fold modulo
// 2^31-1; a rejected set seed or an unused command runs no step and returns zero.
// Reset clears the seed, sets the fallback seed to 1 and drops the filled flag.
// A stalled output holds its beat in the output register while the next command
// runs; only the hand-off of that command's result waits for it.
// ---------------------------------------------------------------------------
`include "park_miller_buffered_stream_macros.svh"

module park_miller_buffered_stream #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] seed_fraction, [38:32] entry_index, [39] zero
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] value, [31] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data   // fallback_seed
);
  import pmbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [30:0] out_value;

  // Fallback seed writes are always taken; write only between commands
  assign cfg_ready = 1'b1;

  pmbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pmbs_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item_op   (s_tuser),
    .item_frac (s_tdata[31:0]),
    .item_idx  (s_tdata[38:32]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .out_value (out_value)
  );

  // Pad the value to a whole number of bytes
  assign m_tdata = {1'b0, out_value};

  // Once a command beat is taken, take no other until its result is handed off
  `PMBS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "second beat")
  // Load the output register only when it is free
  `PMBS_ASSERT_SAME(a_out_load_free, clk, rst, cmd.out_load, status.out_free, "output busy")
  // The refill's chosen entry is read only after the whole buffer is written
  `PMBS_ASSERT_SAME(a_pick_after_fill, clk, rst, cmd.rd_pick, status.filled, "pick before fill")
  // Buffer writes happen only while a command is in progress
  `PMBS_ASSERT_SAME(a_fill_busy, clk, rst, cmd.fill_write, !s_tready, "buffer write while idle")

endmodule

// ===== sv/pmbs_datapath.sv =====
// ---------------------------------------------------------------------------
// Park-Miller buffered stream: datapath
// Seed register, generator step with a registered product, entry buffer
// memory, result and output registers, fallback seed register.
// ---------------------------------------------------------------------------
module pmbs_datapath #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  pmbs_pkg::dp_cmd_t   cmd,
  output pmbs_pkg::dp_status_t status,
  input  logic [2:0]          item_op,
  input  logic [31:0]         item_frac,
  input  logic [6:0]          item_idx,
  input  logic                cfg_valid,
  input  logic [30:0]         cfg_data,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [30:0]         out_value
);
  import pmbs_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int DW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_C = DW'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(BUFFER_DEPTH - 1);

  logic [2:0]      op_r;
  logic [31:0]     frac_r;
  logic [6:0]      idx_r;
  logic [30:0]     fallback;
  logic [31:0]     seed;
  logic [31:0]     seed_src;
  logic [46:0]     prod;
  logic [31:0]     fold;
  logic [31:0]     fold_sub;
  logic [31:0]     seed_next;
  logic [30+DW:0]  pick_prod;
  logic [AW-1:0]   pick;
  logic [AW-1:0]   cnt;
  logic            filled;
  logic [30:0]     mem [BUFFER_DEPTH];
  logic [30:0]     rdata;
  logic            rd_ok;
  logic            idx_ok;
  logic [30:0]     res;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      op_r   <= item_op;
      frac_r <= item_frac;
      idx_r  <= item_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback <= FALLBACK_RST;
    end else if (cfg_valid) begin
      fallback <= cfg_data;
    end
  end

  // Generator step: multiply, then fold modulo 2^31-1
  assign seed_src = (seed == 32'd0) ? {1'b0, fallback} : seed;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 47'(seed_src) * 47'(PM_MULT);
    end
  end

  always_comb begin
    fold     = 32'(prod[30:0]) + 32'(prod[46:31]);
    fold_sub = (fold >= PM_MODULUS) ? fold - PM_MODULUS : fold;
    seed_next = (fold_sub == 32'd0) ? PM_MODULUS : fold_sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cmd.load_seed_frac) begin
      seed <= frac_r;
    end else if (cmd.load_seed_fallback) begin
      seed <= {1'b0, fallback};
    end else if (cmd.reduce) begin
      seed <= seed_next;
    end
  end

  // Selector entry: (selector * depth) >> 31
  assign pick_prod = (31+DW)'(seed[30:0]) * (31+DW)'(DEPTH_C);

  always_ff @(posedge clk) begin
    if (cmd.pick_load) begin
      pick <= pick_prod[31 +: AW];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_cnt) begin
      cnt <= '0;
    end else if (cmd.fill_write) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (cmd.fill_write && (cnt == LAST_C)) begin
      filled <= 1'b1;
    end
  end

  // Entry buffer
  always_ff @(posedge clk) begin
    if (cmd.fill_write) begin
      mem[cnt] <= seed_next[30:0];
    end
  end

  assign idx_ok = (int'(idx_r) < BUFFER_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.rd_pick) begin
      rdata <= mem[pick];
      rd_ok <= 1'b1;
    end else if (cmd.rd_idx) begin
      rdata <= mem[AW'(idx_r)];
      rd_ok <= filled & idx_ok;
    end
  end

  // Pending result, then output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_src)
        RES_STEP: res <= seed_next[30:0];
        RES_MEM:  res <= rd_ok ? rdata : '0;
        default:  res <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= res;
    end
  end

  assign status.op        = op_r;
  assign status.frac_ok   = (frac_r <= SEED_MAX);
  assign status.fill_last = (cnt == LAST_C);
  assign status.filled    = filled;
  assign status.out_free  = ~m_tvalid | m_tready;

endmodule

// ===== sv/pmbs_ctrl.sv =====
// ---------------------------------------------------------------------------
// Park-Miller buffered stream: controller
// Sequences one command at a time through the datapath.
// ---------------------------------------------------------------------------
module pmbs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  pmbs_pkg::dp_status_t status,
  output pmbs_pkg::dp_cmd_t    cmd
);
  import pmbs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (status.op)
          OP_DRAW:   state_next = ST_DRAW_MUL;
          OP_REFILL: state_next = ST_SEL_MUL;
          OP_SET:    state_next = status.frac_ok ? ST_SEL_MUL : ST_DONE;
          OP_READ:   state_next = ST_RD_WAIT;
          OP_RESEED: state_next = ST_SEL_MUL;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_DRAW_MUL: state_next = ST_DRAW_RED;
      ST_DRAW_RED: state_next = ST_DONE;
      ST_SEL_MUL:  state_next = ST_SEL_RED;
      ST_SEL_RED:  state_next = ST_PICK;
      ST_PICK:     state_next = ST_FILL_RED;
      ST_FILL_MUL: state_next = ST_FILL_RED;
      ST_FILL_RED: state_next = status.fill_last ? ST_RD_PICK : ST_FILL_MUL;
      ST_RD_PICK:  state_next = ST_RD_WAIT;
      ST_RD_WAIT:  state_next = ST_DONE;
      ST_DONE:     if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.res_src = RES_ZERO;
    s_tready    = 1'b0;
    unique case (state) inside
      ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.latch_item = s_tvalid;
      end
      ST_DISPATCH: begin
        unique case (status.op) inside
          OP_DRAW, OP_REFILL: ;
          OP_SET: begin
            cmd.load_seed_frac = status.frac_ok;
            cmd.res_load       = ~status.frac_ok;
          end
          OP_READ:   cmd.rd_idx = 1'b1;
          OP_RESEED: cmd.load_seed_fallback = 1'b1;
          default:   cmd.res_load = 1'b1;
        endcase
      end
      ST_DRAW_MUL, ST_SEL_MUL, ST_FILL_MUL: cmd.mul = 1'b1;
      ST_DRAW_RED: begin
        cmd.reduce   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_STEP;
      end
      ST_SEL_RED: cmd.reduce = 1'b1;
      ST_PICK: begin
        cmd.pick_load = 1'b1;
        cmd.clr_cnt   = 1'b1;
        cmd.mul       = 1'b1;
      end
      ST_FILL_RED: begin
        cmd.reduce     = 1'b1;
        cmd.fill_write = 1'b1;
      end
      ST_RD_PICK: cmd.rd_pick = 1'b1;
      ST_RD_WAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_MEM;
      end
      ST_DONE:  cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_park_miller_buffered_stream.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Park-Miller buffered stream: self-checking testbench
// Feeds command beats from a queue, predicts each returned value with a local
// model of the x16807 mod 2^31-1 generator and its entry buffer, and checks
// every output beat in order. The run steps through several fallback seeds
// and through mixes of input idling and output stalls.
// ---------------------------------------------------------------------------
module tb_park_miller_buffered_stream;
  import pmbs_pkg::*;

  localparam int DEPTH      = 128;
  localparam int LONG_HOLD  = 400;       // output held off for this many cycles
  localparam int SETTLE     = 20;        // quiet cycles after the last value
  localparam int LIMIT      = 1_500_000; // cycle budget before giving up

  // Opcodes the block does not define; it answers them with a zero value
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] frac;
    logic [6:0]  entry;
  } pm_cmd_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;  // [31:0] seed_fraction, [38:32] entry_index, [39] zero
  logic [2:0]  s_tuser   = '0;  // [2:0] cmd
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;         // [30:0] value, [31] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data  = '0;  // fallback_seed

  // Local image of the generator state
  logic [31:0] pm_seed     = '0;
  logic [30:0] pm_fallback = FALLBACK_RST;
  logic [30:0] pm_buf [DEPTH];

  pm_cmd_t     cmd_q[$];    // commands waiting to be offered
  logic [30:0] value_q[$];  // predicted values, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic stall_req = 1'b0;   // toggle to ask the receiver for one long hold
  logic stall_ack = 1'b0;
  int hold_left = 0;

  int error_count    = 0;
  int items_sent     = 0;
  int values_checked = 0;
  int refill_count   = 0;
  int cycle_count    = 0;

  park_miller_buffered_stream #(.BUFFER_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // One generator step: a zero seed falls back, a zero product becomes 2^31-1
  function automatic logic [30:0] pm_next();
    logic [63:0] s;
    logic [63:0] r;
    s = (pm_seed == '0) ? 64'(pm_fallback) : 64'(pm_seed);
    r = (s * 64'(PM_MULT)) % 64'(PM_MODULUS);
    if (r == '0) r = 64'(PM_MODULUS);
    pm_seed = r[31:0];
    return r[30:0];
  endfunction

  // Draw the selector, reload every entry, return the selected one
  function automatic logic [30:0] pm_reload();
    logic [30:0] sel;
    int pick;
    sel  = pm_next();
    pick = int'((64'(sel) * 64'(DEPTH)) >> 31);
    if (pick >= DEPTH) pick = DEPTH - 1;
    for (int i = 0; i < DEPTH; i++) pm_buf[i] = pm_next();
    refill_count++;
    return pm_buf[pick];
  endfunction

  // Value that the block must return for one accepted command
  function automatic logic [30:0] predict_value(logic [2:0] op, logic [31:0] frac,
                                                logic [6:0] entry);
    logic [30:0] v;
    v = '0;
    case (op)
      OP_DRAW:   v = pm_next();
      OP_REFILL: v = pm_reload();
      OP_SET: begin
        // out-of-range fractions leave the state alone and return zero
        if (frac <= SEED_MAX) begin
          pm_seed = frac;
          v = pm_reload();
        end
      end
      OP_READ: begin
        if (int'(entry) < DEPTH) v = pm_buf[entry];
      end
      OP_RESEED: begin
        pm_seed = {1'b0, pm_fallback};
        v = pm_reload();
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic pm_cmd_t mk_cmd(logic [2:0] op, logic [31:0] frac, logic [6:0] entry);
    pm_cmd_t c;
    c.op    = op;
    c.frac  = frac;
    c.entry = entry;
    return c;
  endfunction

  // Random command: mostly draws and reads, a steady share of reloads,
  // and some unused opcodes and out-of-range seeds as noise
  function automatic pm_cmd_t rand_cmd();
    pm_cmd_t c;
    int r;
    int k;
    r       = $urandom_range(99);
    k       = $urandom_range(9);
    c.frac  = $urandom;
    c.entry = 7'($urandom_range(DEPTH - 1));
    if (r < 42) begin
      c.op = OP_DRAW;
    end else if (r < 66) begin
      c.op = OP_READ;
    end else if (r < 73) begin
      c.op = OP_REFILL;
    end else if (r < 84) begin
      c.op = OP_SET;
      case (k)
        0: c.frac = '0;
        1: c.frac = SEED_MAX;
        2: c.frac = PM_MODULUS;
        3: c.frac = SEED_MAX + 32'd1 + $urandom_range(32'h7FFF_FFFE);
        default: c.frac = $urandom_range(SEED_MAX);
      endcase
    end else if (r < 90) begin
      c.op = OP_RESEED;
    end else begin
      case (k % 3)
        0: c.op = OP_SPARE_5;
        1: c.op = OP_SPARE_6;
        default: c.op = OP_SPARE_7;
      endcase
    end
    return c;
  endfunction

  // Command driver: hold a beat until taken, then offer the next one or idle
  always @(posedge clk) begin : drive_cmds
    pm_cmd_t nxt;
    logic waiting;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      waiting = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        value_q.push_back(predict_value(s_tuser, s_tdata[31:0], s_tdata[38:32]));
        items_sent++;
      end
      if (!waiting) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.op;
          s_tdata  <= {1'b0, nxt.entry, nxt.frac};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Value monitor: compare each output beat with the oldest prediction,
  // then pick the next ready level (random stall or a long hold)
  always @(posedge clk) begin : take_values
    logic [30:0] want;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      stall_ack = stall_req;
    end else begin
      if (m_tvalid && m_tready) begin
        if (value_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected value beat, expected none, actual 0x%08h",
                   $time, m_tdata[30:0]);
        end else begin
          want = value_q.pop_front();
          values_checked++;
          if (m_tdata[30:0] !== want) begin
            error_count++;
            $display("%0t: value mismatch, expected 0x%08h, actual 0x%08h",
                     $time, want, m_tdata[30:0]);
          end
        end
      end
      if (stall_ack != stall_req) begin
        stall_ack = stall_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Wait until every queued command is taken and every value is back
  task automatic drain();
    while (cmd_q.size() > 0 || s_tvalid || value_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the fallback seed over the config channel; update the image on the beat
  task automatic write_fallback(logic [30:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    pm_fallback = v;
  endtask

  // One phase: idle block, new fallback seed, idling mix, then random traffic.
  // Each phase opens with a zero seed and a reseed so the fallback gets used.
  task automatic run_phase(logic [30:0] fallback, int send_pct, int recv_pct, int count,
                           bit long_hold);
    drain();
    write_fallback(fallback);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) stall_req <= ~stall_req;
    cmd_q.push_back(mk_cmd(OP_SET, '0, '0));
    cmd_q.push_back(mk_cmd(OP_DRAW, '0, '0));
    cmd_q.push_back(mk_cmd(OP_RESEED, '0, '0));
    repeat (count) cmd_q.push_back(rand_cmd());
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) pm_buf[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads before any fill, draw from a zero seed, unused opcodes,
    // out-of-range and extreme seeds, the stuck seed, both entry extremes
    cmd_q.push_back(mk_cmd(OP_READ, '0, 7'd0));
    cmd_q.push_back(mk_cmd(OP_READ, 32'hFFFF_FFFF, 7'd127));
    cmd_q.push_back(mk_cmd(OP_DRAW, '0, '0));
    cmd_q.push_back(mk_cmd(OP_SPARE_5, 32'h8000_0000, 7'd127));
    cmd_q.push_back(mk_cmd(OP_SPARE_6, '0, '0));
    cmd_q.push_back(mk_cmd(OP_SPARE_7, 32'h5555_5555, 7'h55));
    cmd_q.push_back(mk_cmd(OP_SET, 32'hFFFF_FFFF, 7'd127));
    cmd_q.push_back(mk_cmd(OP_SET, SEED_MAX + 32'd1, '0));
    cmd_q.push_back(mk_cmd(OP_READ, '0, 7'd0));
    cmd_q.push_back(mk_cmd(OP_SET, SEED_MAX, '0));
    cmd_q.push_back(mk_cmd(OP_READ, '0, 7'd0));
    cmd_q.push_back(mk_cmd(OP_READ, '0, 7'd127));
    cmd_q.push_back(mk_cmd(OP_DRAW, '0, '0));
    cmd_q.push_back(mk_cmd(OP_REFILL, '0, '0));
    cmd_q.push_back(mk_cmd(OP_READ, '0, 7'd64));
    cmd_q.push_back(mk_cmd(OP_SET, PM_MODULUS, '0));
    cmd_q.push_back(mk_cmd(OP_DRAW, '0, '0));
    cmd_q.push_back(mk_cmd(OP_DRAW, '0, '0));
    cmd_q.push_back(mk_cmd(OP_RESEED, '0, '0));
    cmd_q.push_back(mk_cmd(OP_SET, '0, '0));
    cmd_q.push_back(mk_cmd(OP_READ, '0, 7'd1));
    cmd_q.push_back(mk_cmd(OP_SET, 32'd1, 7'd126));
    cmd_q.push_back(mk_cmd(OP_DRAW, '0, '0));

    // Random phases across fallback extremes and idling mixes; the first one
    // holds the output off long enough to back the block up into its input
    run_phase(31'd0, 0, 0, 85, 1'b1);
    run_phase(31'h7FFF_FFFF, 87, 0, 85, 1'b0);
    run_phase(31'h7FFF_FFFE, 0, 87, 85, 1'b0);
    run_phase(31'd1, 29, 29, 85, 1'b0);
    run_phase(31'($urandom_range(32'h7FFF_FFFE, 1)), 0, 0, 80, 1'b0);
    drain();

    if (value_q.size() != 0) error_count++;
    $display("Run covered %0d commands and %0d checked values, with %0d buffer reloads,",
             items_sent, values_checked, refill_count);
    $display("fallback seeds 0, 1, 2^31-2, 2^31-1 and random, idle and stall mixes.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: stop a run that hangs
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d values outstanding",
             $time, cycle_count, value_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pmbs_pkg.sv
sv/pmbs_datapath.sv
sv/pmbs_ctrl.sv
sv/park_miller_buffered_stream.sv
tb/tb_park_miller_buffered_stream.sv
